// ----- sv/lcbf_pkg.sv -----
// Shared types, command codes and sizing constants for the countdown bar fader.
`default_nettype none
package lcbf_pkg;

  // Sizing
  localparam int LCBF_MAX_LEDS = 64;
  localparam int DUR_W         = 16;
  localparam int CNT_W         = 7;
  localparam int COLOR_W       = 24;
  localparam int TIME_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;
  localparam int MS_PER_SEC    = 1000;

  // Event kinds as carried on in_mode and through the command queue
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COL   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [DUR_W-1:0]   RST_DURATION  = 16'd60;
  localparam logic [CNT_W-1:0]   RST_LED_COUNT = 7'd64;
  localparam logic [COLOR_W-1:0] RST_START_COL = 24'h00FF00;
  localparam logic [COLOR_W-1:0] RST_END_COL   = 24'hFF0000;

  // Classified command: frames carry elapsed time, other kinds carry now_ms
  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] arg;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- sv/led_countdown_bar_fader_top.sv -----
// Top level of the LED countdown bar fader: configuration registers and block wiring.
//
//  - Events enter on in_mode/in_now_ms, taken at an edge where start is high
//    and busy is low. Modes: frame, start, stop, clear.
//  - A two-entry command queue sits behind the input; busy rises only when it
//    is full. Start/stop/clear events leave the queue while the back end idles.
//  - A frame runs in the back end as a prep step, a 16-step restoring divide,
//    a check step, a target step, then one LED per cycle up to the clipped LED
//    count. An expired frame or one at zero elapsed time skips the divide; a
//    status frame ends after the check step. An LED beat reaches the out_
//    ports through the walk state, the s1 stage and the result register; a
//    status beat is registered straight from the check step.
//  - Results appear on the out_ ports for one cycle marked by out_valid. The
//    receiver cannot stall; every beat must be taken as it comes.
//  - Configuration is a plain write port (cfg_we, cfg_index, cfg_data), only
//    to be used while no event is pending.
//  - Reset loads the default configuration, stops the timer, zeroes the start
//    stamp and marks every pixel black through per-entry valid bits.
//  - Clear blacks the whole pixel store at once through the valid bits.
`default_nettype none
module led_countdown_bar_fader_top
  import lcbf_pkg::*;
#(
  parameter int MAX_LEDS = LCBF_MAX_LEDS
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_mode,
  input  wire logic [TIME_W-1:0]     in_now_ms,
  output logic                       out_valid,
  output logic [5:0]                 out_led_index,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic                       out_pixel_valid,
  output logic                       out_running,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DUR_W-1:0]   duration_r;
  logic [CNT_W-1:0]   led_cnt_r;
  logic [COLOR_W-1:0] start_col_r;
  logic [COLOR_W-1:0] end_col_r;

  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  q_stat_t q_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r  <= RST_DURATION;
      led_cnt_r   <= RST_LED_COUNT;
      start_col_r <= RST_START_COL;
      end_col_r   <= RST_END_COL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DURATION:  duration_r  <= cfg_data[DUR_W-1:0];
        CFG_LED_COUNT: led_cnt_r   <= cfg_data[CNT_W-1:0];
        CFG_START_COL: start_col_r <= cfg_data[COLOR_W-1:0];
        CFG_END_COL:   end_col_r   <= cfg_data[COLOR_W-1:0];
        default:       duration_r  <= duration_r;
      endcase
    end
  end

  assign busy = q_stat.full;

  lcbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .mode     (in_mode),
    .now_ms   (in_now_ms),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lcbf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  lcbf_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_cmd         (pop_cmd),
    .pop             (pop),
    .cfg_duration    (duration_r),
    .cfg_led_cnt     (led_cnt_r),
    .cfg_start_col   (start_col_r),
    .cfg_end_col     (end_col_r),
    .out_valid       (out_valid),
    .out_led_index   (out_led_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_pixel_valid (out_pixel_valid),
    .out_running     (out_running),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// ----- sv/lcbf_front.sv -----
// Front end: accepts events, keeps the start stamp and classifies frames by elapsed time.
`default_nettype none
module lcbf_front
  import lcbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        mode,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire q_stat_t           q_stat,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic [TIME_W-1:0] stamp_r;

  // Take a beat whenever the queue has room
  assign push = start & ~q_stat.full;

  // Frames go down with elapsed time, everything else with the raw time
  always_comb begin
    push_cmd.op  = mode;
    push_cmd.arg = (mode == OP_FRAME) ? (now_ms - stamp_r) : now_ms;
  end

  // Latch the start stamp on a start event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
    end else if (push && mode == OP_START) begin
      stamp_r <= now_ms;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lcbf_queue.sv -----
// Two-entry command queue between the front end and the back end.
`default_nettype none
module lcbf_queue
  import lcbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output q_stat_t   q_stat
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign pop_cmd      = entry_r[rd_ptr_r];
  assign q_stat.empty = (count_r == 2'd0);
  assign q_stat.full  = (count_r == 2'd2);

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("queue popped while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ----- sv/lcbf_back.sv -----
// Back end: runs timer events, divides out the remaining fraction and walks the LEDs.
`default_nettype none
module lcbf_back
  import lcbf_pkg::*;
#(
  parameter int MAX_LEDS = LCBF_MAX_LEDS
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire q_stat_t            q_stat,
  input  wire cmd_t               pop_cmd,
  output logic                    pop,
  input  wire logic [DUR_W-1:0]   cfg_duration,
  input  wire logic [CNT_W-1:0]   cfg_led_cnt,
  input  wire logic [COLOR_W-1:0] cfg_start_col,
  input  wire logic [COLOR_W-1:0] cfg_end_col,
  output logic                    out_valid,
  output logic [5:0]              out_led_index,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_pixel_valid,
  output logic                    out_running,
  output logic                    out_last
);

  localparam int IW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int DMS_W = 26;
  localparam int R_W   = 17;
  localparam int POS_W = R_W + CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_TGT  = 3'd4;
  localparam logic [2:0] S_WALK = 3'd5;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic               active_r;
  logic [TIME_W-1:0]  elapsed_r;
  logic [DMS_W-1:0]   dms_r;
  logic [DMS_W-1:0]   rem_r;
  logic [3:0]         step_r;
  logic [R_W-1:0]     r_r;
  logic [7:0]         f_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   i_r;
  logic [COLOR_W-1:0] target_r;
  logic [POS_W-1:0]   pos_r;

  logic               s1_v_r;
  logic [CNT_W-1:0]   s1_idx_r;
  logic [7:0]         s1_bl_r;
  logic               s1_last_r;

  logic [COLOR_W-1:0] pix_mem_r [MAX_LEDS];
  logic [MAX_LEDS-1:0] pix_vld_r;
  logic [COLOR_W-1:0] rd_data_r;
  logic               rd_vld_r;

  logic               out_valid_r;
  logic [5:0]         out_idx_r;
  logic [COLOR_W-1:0] out_rgb_r;
  logic               out_pv_r;
  logic               out_run_r;
  logic               out_last_r;

  logic [DMS_W:0]     rem2;
  logic               q_bit;
  logic [R_W+8:0]     f_prod;
  logic [CNT_W-1:0]   n_clip;
  logic signed [DMS_W-1:0] d_s;
  logic [17:0]        d_u;
  logic [DMS_W-1:0]   bl_prod;
  logic [7:0]         bl;
  logic               issue;
  logic [COLOR_W-1:0] old_rgb;
  logic [COLOR_W-1:0] new_rgb;

  // One channel of the fade: move a toward b by (delta*(f+1))>>8
  function automatic logic [7:0] lerp_chan(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] f);
    logic [7:0]  delta;
    logic [8:0]  f1;
    logic [16:0] prod;
    logic [7:0]  s;
    begin
      delta = (b > a) ? (b - a) : (a - b);
      f1    = {1'b0, f} + 9'd1;
      prod  = 17'(delta) * 17'(f1);
      s     = prod[15:8];
      lerp_chan = (b > a) ? (a + s) : (a - s);
    end
  endfunction

  function automatic logic [COLOR_W-1:0] lerp_rgb(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b,
                                                  input logic [7:0] f);
    begin
      lerp_rgb = {lerp_chan(a[23:16], b[23:16], f),
                  lerp_chan(a[15:8],  b[15:8],  f),
                  lerp_chan(a[7:0],   b[7:0],   f)};
    end
  endfunction

  assign pop = (state_r == S_IDLE) && !q_stat.empty;

  // Restoring divide step
  assign rem2  = {rem_r, 1'b0};
  assign q_bit = (rem2 >= {1'b0, dms_r});

  // Target fraction f = floor(255*r / 65536)
  assign f_prod = {r_r, 8'b0} - (R_W+9)'(r_r);
  assign n_clip = (cfg_led_cnt > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : cfg_led_cnt;

  // Edge blend for LED i from d = pos + 1 - i in 16-bit fraction units
  assign issue   = (state_r == S_WALK);
  assign d_s     = $signed(DMS_W'(pos_r)) + $signed(DMS_W'(32'd65536))
                 - $signed(DMS_W'({i_r, 16'b0}));
  assign d_u     = d_s[17:0];
  assign bl_prod = DMS_W'({d_u, 8'b0}) - DMS_W'(d_u);
  always_comb begin
    if (d_s < 0) begin
      bl = 8'd0;
    end else if (d_s > $signed(DMS_W'(32'd131072))) begin
      bl = 8'd255;
    end else begin
      bl = bl_prod[24:17];
    end
  end

  // Blend the stored colour toward the target
  assign old_rgb = rd_vld_r ? rd_data_r : '0;
  assign new_rgb = lerp_rgb(old_rgb, target_r, s1_bl_r);

  // Sequence the back end
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop && pop_cmd.op == OP_FRAME) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if ({6'b0, dms_r} <= elapsed_r || elapsed_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == 4'd15) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!active_r || r_r == '0 || n_clip == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (i_r + CNT_W'(1) == n_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      s1_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      if (pop && pop_cmd.op == OP_START) begin
        active_r <= 1'b1;
      end else if (pop && pop_cmd.op == OP_STOP) begin
        active_r <= 1'b0;
      end else if (state_r == S_CHK && (!active_r || r_r == '0)) begin
        active_r <= 1'b0;
      end
    end
  end

  // Datapath: divide, target, position and LED walk
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        elapsed_r <= pop_cmd.arg;
        dms_r     <= DMS_W'(cfg_duration) * DMS_W'(MS_PER_SEC);
      end
      S_PREP: begin
        rem_r  <= dms_r - elapsed_r[DMS_W-1:0];
        step_r <= 4'd0;
        if ({6'b0, dms_r} <= elapsed_r) begin
          r_r <= '0;
        end else if (elapsed_r == '0) begin
          r_r <= R_W'(32'd65536);
        end else begin
          r_r <= '0;
        end
      end
      S_DIV: begin
        rem_r  <= q_bit ? DMS_W'(rem2 - {1'b0, dms_r}) : rem2[DMS_W-1:0];
        r_r    <= {r_r[R_W-2:0], q_bit};
        step_r <= step_r + 4'd1;
      end
      S_CHK: begin
        f_r <= f_prod[23:16];
        n_r <= n_clip;
      end
      S_TGT: begin
        target_r <= lerp_rgb(cfg_end_col, cfg_start_col, f_r);
        pos_r    <= POS_W'(r_r) * POS_W'(n_r);
        i_r      <= '0;
      end
      S_WALK: begin
        i_r <= i_r + CNT_W'(1);
      end
      default: begin
        i_r <= i_r;
      end
    endcase
    s1_idx_r  <= i_r;
    s1_bl_r   <= bl;
    s1_last_r <= (i_r + CNT_W'(1) == n_r);
  end

  // Pixel store: read the LED being issued, write back the blended colour
  always_ff @(posedge clk) begin
    rd_data_r <= pix_mem_r[i_r[IW-1:0]];
    if (s1_v_r) begin
      pix_mem_r[s1_idx_r[IW-1:0]] <= new_rgb;
    end
  end

  // Entry valid bits: unwritten or cleared entries read as black; a clear
  // taken while the last LED of a frame is written back wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= pix_vld_r[i_r[IW-1:0]];
      if (pop && pop_cmd.op == OP_CLEAR) begin
        pix_vld_r <= '0;
      end else if (s1_v_r) begin
        pix_vld_r[s1_idx_r[IW-1:0]] <= 1'b1;
      end
    end
  end

  // Result register: LED beats from the walk, status beats from the check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_v_r || (state_r == S_CHK &&
                     (!active_r || r_r == '0 || n_clip == '0));
    end
    if (s1_v_r) begin
      out_idx_r  <= s1_idx_r[5:0];
      out_rgb_r  <= new_rgb;
      out_pv_r   <= 1'b1;
      out_run_r  <= 1'b1;
      out_last_r <= s1_last_r;
    end else begin
      out_idx_r  <= '0;
      out_rgb_r  <= '0;
      out_pv_r   <= 1'b0;
      out_run_r  <= active_r && (r_r != '0);
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_index   = out_idx_r;
  assign out_red         = out_rgb_r[23:16];
  assign out_green       = out_rgb_r[15:8];
  assign out_blue        = out_rgb_r[7:0];
  assign out_pixel_valid = out_pv_r;
  assign out_running     = out_run_r;
  assign out_last        = out_last_r;

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel_valid) |-> out_last)
    else $error("status beat without last");

  a_walk_has_leds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (n_r != '0 && i_r < n_r))
    else $error("LED walk out of range");

  a_issue_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> (out_valid && out_pixel_valid && out_running))
    else $error("issued LED produced no pixel beat");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE))
    else $error("command taken while back end busy");

endmodule
`default_nettype wire
